FILE: rtl/ucrh_pkg.sv
`default_nettype none

package ucrh_pkg;

    localparam int TABLE_ENTRIES_DEF = 8;
    localparam int PACKET_BYTES_DEF  = 64;
    localparam int ENDPOINTS_DEF     = 4;

    // action codes of an input word
    localparam logic [2:0] ACT_SETUP     = 3'd0;
    localparam logic [2:0] ACT_BUS_RESET = 3'd1;
    localparam logic [2:0] ACT_IN_READY  = 3'd2;
    localparam logic [2:0] ACT_OUT_ABORT = 3'd3;
    localparam logic [2:0] ACT_LOAD      = 3'd4;

    // response codes of an output word
    localparam logic [2:0] RESP_STALL     = 3'd0;
    localparam logic [2:0] RESP_ACK       = 3'd1;
    localparam logic [2:0] RESP_MEM_DATA  = 3'd2;
    localparam logic [2:0] RESP_INLINE    = 3'd3;
    localparam logic [2:0] RESP_SET_ADDR  = 3'd4;
    localparam logic [2:0] RESP_CONFIGURE = 3'd5;
    localparam logic [2:0] RESP_HALT      = 3'd6;
    localparam logic [2:0] RESP_UNHALT    = 3'd7;

    // standard request codes
    localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
    localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'd1;
    localparam logic [7:0] REQ_SET_FEATURE       = 8'd3;
    localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
    localparam logic [7:0] REQ_DESC_READ         = 8'd6;
    localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
    localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;

    // request types
    localparam logic [7:0] RT_DEV_OUT = 8'h00;
    localparam logic [7:0] RT_DEV_IN  = 8'h80;
    localparam logic [7:0] RT_EP_OUT  = 8'h02;
    localparam logic [7:0] RT_EP_IN   = 8'h82;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] value_word;
        logic [15:0] index_word;
        logic [15:0] length_word;
        logic [2:0]  slot;
        logic [15:0] desc_base;
        logic [7:0]  desc_size;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  response;
        logic [15:0] mem_addr;
        logic [6:0]  byte_count;
        logic [15:0] inline_data;
        logic [6:0]  device_address;
        logic [7:0]  config_value;
        logic [2:0]  endpoint_num;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic [15:0] key_value;
        logic [15:0] key_index;
        logic [15:0] base;
        logic [7:0]  size;
    } entry_t;

    typedef struct packed {
        logic        start;
        logic [15:0] key_value;
        logic [15:0] key_index;
    } search_req_t;

    typedef struct packed {
        logic        done;
        logic        hit;
        logic [15:0] base;
        logic [7:0]  size;
    } search_res_t;

endpackage

`default_nettype wire

FILE: rtl/ucrh_ram.sv
`default_nettype none

module ucrh_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/ucrh_search.sv
`default_nettype none

module ucrh_search #(
    parameter int TABLE_ENTRIES = ucrh_pkg::TABLE_ENTRIES_DEF,
    parameter int ADDR_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
    parameter int CNT_W         = $clog2(TABLE_ENTRIES + 1)
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [CNT_W-1:0]       count,
    input  wire ucrh_pkg::search_req_t  req,
    output logic      [ADDR_W-1:0]      rd_addr,
    input  wire ucrh_pkg::entry_t       rd_data,
    output ucrh_pkg::search_res_t       res
);

    typedef enum logic [1:0] {S_IDLE, S_FETCH, S_CHECK} state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      idx_inc;
    logic [15:0]           kval_reg, kval_next;
    logic [15:0]           kidx_reg, kidx_next;
    ucrh_pkg::search_res_t res_reg, res_next;

    assign idx_inc = idx_reg + CNT_W'(1);
    assign rd_addr = idx_reg[ADDR_W-1:0];
    assign res     = res_reg;

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        kval_next     = kval_reg;
        kidx_next     = kidx_reg;
        res_next      = res_reg;
        res_next.done = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    kval_next = req.key_value;
                    kidx_next = req.key_index;
                    idx_next  = '0;
                    if (count == '0)
                    begin
                        res_next.done = 1'b1;
                        res_next.hit  = 1'b0;
                    end
                    else
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                // shared key compare on the entry read last cycle
                if (rd_data.key_value == kval_reg && rd_data.key_index == kidx_reg)
                begin
                    res_next.done = 1'b1;
                    res_next.hit  = 1'b1;
                    res_next.base = rd_data.base;
                    res_next.size = rd_data.size;
                    state_next    = S_IDLE;
                end
                else if (idx_inc == count)
                begin
                    res_next.done = 1'b1;
                    res_next.hit  = 1'b0;
                    state_next    = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_FETCH;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            kval_reg  <= '0;
            kidx_reg  <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            kval_reg  <= kval_next;
            kidx_reg  <= kidx_next;
            res_reg   <= res_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/usb_control_request_handler.sv
// Standard request handler for the USB control endpoint. One input word is taken at a time;
// in_ready is low while a word is being worked on, and also while a finished result is waiting
// and not being taken. Bus reset, OUT abort, table loads and all setup requests other than a
// descriptor request are handled as the word is taken, and an IN ready with a transfer in
// flight goes through the packet state. A descriptor request walks the descriptor table
// through its RAM (one write port, one read port), fetching and then checking one entry at a
// time. On a hit the search stops at the first matching entry and the first data packet
// follows; on a miss a stall follows once all entries are searched (descriptor_count, at
// most the table size). Table entries read before being loaded give unspecified results.
`default_nettype none

module usb_control_request_handler #(
    parameter int TABLE_ENTRIES = ucrh_pkg::TABLE_ENTRIES_DEF,
    parameter int PACKET_BYTES  = ucrh_pkg::PACKET_BYTES_DEF,
    parameter int ENDPOINTS     = ucrh_pkg::ENDPOINTS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write_en,
    input  wire logic [3:0]          cfg_write_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire ucrh_pkg::in_word_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output ucrh_pkg::out_word_t      out_data
);

    localparam int         AddrW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int         CntW     = $clog2(TABLE_ENTRIES + 1);
    localparam logic [7:0] PktBytes = 8'(PACKET_BYTES);
    localparam logic [6:0] EpMax    = 7'(ENDPOINTS);

    typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_PACKET} state_t;

    state_t              state_reg, state_next;
    logic [3:0]          desc_count_reg;
    logic [7:0]          config_reg, config_next;
    logic [ENDPOINTS-1:0] halt_reg, halt_next;
    logic                xfer_active_reg, xfer_active_next;
    logic [7:0]          xfer_rem_reg, xfer_rem_next;
    logic [15:0]         xfer_addr_reg, xfer_addr_next;
    logic [7:0]          len_reg, len_next;
    logic                out_valid_reg, out_valid_next;
    ucrh_pkg::out_word_t out_data_reg, out_data_next;

    logic                accept;
    logic [CntW-1:0]     search_count;
    logic [6:0]          ep;
    logic [6:0]          ep_m1;
    logic                ep_ok;
    logic [ENDPOINTS-1:0] ep_mask;
    logic                ram_we;
    logic [AddrW-1:0]    ram_waddr;
    logic [AddrW-1:0]    ram_raddr;
    ucrh_pkg::entry_t    ram_wdata;
    ucrh_pkg::entry_t    ram_rdata;
    ucrh_pkg::search_req_t srch_req;
    ucrh_pkg::search_res_t srch_res;
    logic [7:0]          pkt_n;
    logic [7:0]          pkt_rem;
    logic                pkt_more;
    logic [7:0]          desc_len;

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        if (32'(desc_count_reg) > TABLE_ENTRIES)
        begin
            search_count = CntW'(TABLE_ENTRIES);
        end
        else
        begin
            search_count = CntW'(desc_count_reg);
        end
    end

    assign ep      = in_data.index_word[6:0];
    assign ep_m1   = ep - 7'd1;
    assign ep_ok   = (ep != 7'd0) && (ep <= EpMax);
    assign ep_mask = ENDPOINTS'(1) << ep_m1;

    // descriptor table writes
    assign ram_we    = accept && (in_data.action == ucrh_pkg::ACT_LOAD)
                       && (32'(in_data.slot) < TABLE_ENTRIES);
    assign ram_waddr = AddrW'(in_data.slot);
    assign ram_wdata.key_value = in_data.value_word;
    assign ram_wdata.key_index = in_data.index_word;
    assign ram_wdata.base      = in_data.desc_base;
    assign ram_wdata.size      = in_data.desc_size;

    assign srch_req.start     = accept && (in_data.action == ucrh_pkg::ACT_SETUP)
                                && (in_data.request_code == ucrh_pkg::REQ_DESC_READ);
    assign srch_req.key_value = in_data.value_word;
    assign srch_req.key_index = in_data.index_word;

    ucrh_ram #(
        .WIDTH  ($bits(ucrh_pkg::entry_t)),
        .DEPTH  (TABLE_ENTRIES),
        .ADDR_W (AddrW)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ucrh_search #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ADDR_W        (AddrW),
        .CNT_W         (CntW)
    ) u_search (
        .clk     (clk),
        .rst_n   (rst_n),
        .count   (search_count),
        .req     (srch_req),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata),
        .res     (srch_res)
    );

    // next packet of the transfer in flight
    assign pkt_n    = (xfer_rem_reg < PktBytes) ? xfer_rem_reg : PktBytes;
    assign pkt_rem  = xfer_rem_reg - pkt_n;
    assign pkt_more = (pkt_rem != 8'd0) || (pkt_n == PktBytes);
    assign desc_len = (len_reg < srch_res.size) ? len_reg : srch_res.size;

    always_comb
    begin
        state_next       = state_reg;
        config_next      = config_reg;
        halt_next        = halt_reg;
        xfer_active_next = xfer_active_reg;
        xfer_rem_next    = xfer_rem_reg;
        xfer_addr_next   = xfer_addr_reg;
        len_next         = len_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_data_next    = out_data_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_data.action)
                        ucrh_pkg::ACT_SETUP:
                        begin
                            xfer_active_next = 1'b0;
                            xfer_rem_next    = '0;
                            xfer_addr_next   = '0;
                            out_data_next    = '0;
                            priority if (in_data.request_code ==
                                         ucrh_pkg::REQ_DESC_READ)
                            begin
                                // wLength clamped to one byte
                                len_next   = (in_data.length_word[15:8] != 8'd0) ?
                                             8'hFF : in_data.length_word[7:0];
                                state_next = ST_SEARCH;
                            end
                            else if (in_data.request_code == ucrh_pkg::REQ_SET_ADDRESS)
                            begin
                                out_valid_next               = 1'b1;
                                out_data_next.response       = ucrh_pkg::RESP_SET_ADDR;
                                out_data_next.device_address = in_data.value_word[6:0];
                            end
                            else if (in_data.request_code == ucrh_pkg::REQ_SET_CONFIGURATION
                                     && in_data.request_type == ucrh_pkg::RT_DEV_OUT)
                            begin
                                config_next                = in_data.value_word[7:0];
                                halt_next                  = '0;
                                out_valid_next             = 1'b1;
                                out_data_next.response     = ucrh_pkg::RESP_CONFIGURE;
                                out_data_next.config_value = in_data.value_word[7:0];
                            end
                            else if (in_data.request_code == ucrh_pkg::REQ_GET_CONFIGURATION
                                     && in_data.request_type == ucrh_pkg::RT_DEV_IN)
                            begin
                                out_valid_next            = 1'b1;
                                out_data_next.response    = ucrh_pkg::RESP_INLINE;
                                out_data_next.byte_count  = 7'd1;
                                out_data_next.inline_data = {8'h00, config_reg};
                                out_data_next.last        = 1'b1;
                            end
                            else if (in_data.request_code == ucrh_pkg::REQ_GET_STATUS)
                            begin
                                out_valid_next            = 1'b1;
                                out_data_next.response    = ucrh_pkg::RESP_INLINE;
                                out_data_next.byte_count  = 7'd2;
                                out_data_next.inline_data = {15'd0,
                                    (in_data.request_type == ucrh_pkg::RT_EP_IN) && ep_ok
                                    && ((halt_reg & ep_mask) != '0)};
                                out_data_next.last        = 1'b1;
                            end
                            else if ((in_data.request_code == ucrh_pkg::REQ_SET_FEATURE
                                      || in_data.request_code == ucrh_pkg::REQ_CLEAR_FEATURE)
                                     && in_data.request_type == ucrh_pkg::RT_EP_OUT
                                     && in_data.value_word == 16'd0 && ep_ok)
                            begin
                                out_valid_next             = 1'b1;
                                out_data_next.endpoint_num = ep[2:0];
                                if (in_data.request_code == ucrh_pkg::REQ_SET_FEATURE)
                                begin
                                    halt_next              = halt_reg | ep_mask;
                                    out_data_next.response = ucrh_pkg::RESP_HALT;
                                end
                                else
                                begin
                                    halt_next              = halt_reg & ~ep_mask;
                                    out_data_next.response = ucrh_pkg::RESP_UNHALT;
                                end
                            end
                            else
                            begin
                                out_valid_next         = 1'b1;
                                out_data_next.response = ucrh_pkg::RESP_STALL;
                            end
                        end
                        ucrh_pkg::ACT_BUS_RESET:
                        begin
                            config_next      = '0;
                            halt_next        = '0;
                            xfer_active_next = 1'b0;
                            xfer_rem_next    = '0;
                            xfer_addr_next   = '0;
                        end
                        ucrh_pkg::ACT_IN_READY:
                        begin
                            if (xfer_active_reg)
                            begin
                                state_next = ST_PACKET;
                            end
                        end
                        ucrh_pkg::ACT_OUT_ABORT:
                        begin
                            xfer_active_next = 1'b0;
                            xfer_rem_next    = '0;
                            xfer_addr_next   = '0;
                        end
                        default:
                        begin
                            // table loads go straight to the RAM, other codes are ignored
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if (srch_res.done)
                begin
                    if (srch_res.hit)
                    begin
                        xfer_active_next = 1'b1;
                        xfer_rem_next    = desc_len;
                        xfer_addr_next   = srch_res.base;
                        state_next       = ST_PACKET;
                    end
                    else
                    begin
                        out_valid_next         = 1'b1;
                        out_data_next          = '0;
                        out_data_next.response = ucrh_pkg::RESP_STALL;
                        state_next             = ST_IDLE;
                    end
                end
            end
            ST_PACKET:
            begin
                out_valid_next           = 1'b1;
                out_data_next            = '0;
                out_data_next.response   = ucrh_pkg::RESP_MEM_DATA;
                out_data_next.mem_addr   = xfer_addr_reg;
                out_data_next.byte_count = pkt_n[6:0];
                out_data_next.last       = !pkt_more;
                xfer_rem_next            = pkt_rem;
                xfer_addr_next           = xfer_addr_reg + {8'd0, pkt_n};
                xfer_active_next         = pkt_more;
                state_next               = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            desc_count_reg  <= '0;
            config_reg      <= '0;
            halt_reg        <= '0;
            xfer_active_reg <= 1'b0;
            xfer_rem_reg    <= '0;
            xfer_addr_reg   <= '0;
            len_reg         <= '0;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                desc_count_reg <= cfg_write_data;
            end
            state_reg       <= state_next;
            config_reg      <= config_next;
            halt_reg        <= halt_next;
            xfer_active_reg <= xfer_active_next;
            xfer_rem_reg    <= xfer_rem_next;
            xfer_addr_reg   <= xfer_addr_next;
            len_reg         <= len_next;
            out_valid_reg   <= out_valid_next;
            out_data_reg    <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    // the search unit only answers a lookup the sequencer is waiting for
    a_search_done_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        srch_res.done |-> state_reg == ST_SEARCH)
        else $error("search result outside of a descriptor lookup");

    // a data packet that is not the last leaves a transfer in flight
    a_more_keeps_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.response == ucrh_pkg::RESP_MEM_DATA
        && !out_data_reg.last |-> xfer_active_reg)
        else $error("non-final packet without an active transfer");

    // a packet never exceeds the control endpoint size
    a_packet_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.response == ucrh_pkg::RESP_MEM_DATA
        |-> 32'(out_data_reg.byte_count) <= PACKET_BYTES)
        else $error("data packet larger than the control size");
`endif

endmodule

`default_nettype wire
